### src/weno5_upwind_derivative_core_assert.svh
// Assertion macros shared by the WENO5 upwind derivative core RTL.
`ifndef WENO5_UPWIND_DERIVATIVE_CORE_ASSERT_SVH
`define WENO5_UPWIND_DERIVATIVE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define W5UD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define W5UD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/weno5ud_pkg.sv
// Shared widths, constants and constant-divisor helpers of the WENO5 derivative core.
package weno5ud_pkg;

  localparam int DATA_W     = 32;
  localparam int EPS_W      = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd17;

  localparam int DIFF_W     = 36;          // second differences
  localparam int SQ_W       = DIFF_W - 8;  // differences floored to Q.16
  localparam int X_W        = 64;          // 13*A^2 + 3*B^2
  localparam int S_W        = 58;          // smoothness plus epsilon, Q.32
  localparam int NUM_W      = 38;          // candidate numerators
  localparam int MAG_W      = 48;          // candidate magnitude, three 16-bit digits
  localparam int F_W        = 35;          // candidate values, Q11.24
  localparam int Q_W        = 32;          // Q1.31 ratios and quotients
  localparam int DEN_W      = 35;          // divider operands
  localparam int W_W        = 25;          // normalised weights, Q.24
  localparam int RES_W      = 40;          // one reconstruction
  localparam int SH_W       = 5;
  localparam int FRAC_BITS  = 24;

  localparam int SMOOTH_LAT = 3;
  localparam int QDIV_LAT   = 8;
  localparam int QDIV_STEPS = Q_W / QDIV_LAT;

  localparam logic [2:0] G_LEFT  [3] = '{3'd1, 3'd6, 3'd3};
  localparam logic [2:0] G_RIGHT [3] = '{3'd3, 3'd6, 3'd1};

  typedef struct packed {
    logic [15:0] q;
    logic [3:0]  r;
  } div12_t;

  typedef struct packed {
    logic [15:0] q;
    logic [2:0]  r;
  } div6_t;

  // One 16-bit digit of a division by 12; r_in is the running remainder.
  function automatic div12_t div12_part(input logic [3:0] r_in, input logic [15:0] chunk);
    logic [19:0] v;
    logic [40:0] prod;
    div12_t      res;
    v     = {r_in, chunk};
    prod  = 41'(v) * 41'd1398102;
    res.q = prod[39:24];
    res.r = 4'(v - 20'(res.q) * 20'd12);
    return res;
  endfunction

  // One 16-bit digit of a division by 6.
  function automatic div6_t div6_part(input logic [2:0] r_in, input logic [15:0] chunk);
    logic [18:0] v;
    logic [38:0] prod;
    div6_t       res;
    v     = {r_in, chunk};
    prod  = 39'(v) * 39'd699051;
    res.q = prod[37:22];
    res.r = 3'(v - 19'(res.q) * 19'd6);
    return res;
  endfunction

endpackage

### src/weno5ud_in_if.sv
// Input channel: velocity and seven-point stencil with valid/ready.
interface weno5ud_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [weno5ud_pkg::DATA_W-1:0] velocity;
  logic signed [weno5ud_pkg::DATA_W-1:0] sample_m3;
  logic signed [weno5ud_pkg::DATA_W-1:0] sample_m2;
  logic signed [weno5ud_pkg::DATA_W-1:0] sample_m1;
  logic signed [weno5ud_pkg::DATA_W-1:0] sample_c;
  logic signed [weno5ud_pkg::DATA_W-1:0] sample_p1;
  logic signed [weno5ud_pkg::DATA_W-1:0] sample_p2;
  logic signed [weno5ud_pkg::DATA_W-1:0] sample_p3;

  modport source (output valid, velocity, sample_m3, sample_m2, sample_m1, sample_c,
                  sample_p1, sample_p2, sample_p3, input ready);
  modport sink   (input valid, velocity, sample_m3, sample_m2, sample_m1, sample_c,
                  sample_p1, sample_p2, sample_p3, output ready);
endinterface

### src/weno5ud_out_if.sv
// Result channel: flux difference with valid/ready.
interface weno5ud_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [weno5ud_pkg::DATA_W-1:0] flux_difference;

  modport source (output valid, flux_difference, input ready);
  modport sink   (input valid, flux_difference, output ready);
endinterface

### src/weno5ud_smooth.sv
// Three-stage smoothness indicator: squares, divide by 12, add epsilon.
module weno5ud_smooth (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   vld_in,
  input  logic signed [weno5ud_pkg::DIFF_W-1:0] a_diff,
  input  logic signed [weno5ud_pkg::DIFF_W-1:0] b_diff,
  input  logic [weno5ud_pkg::EPS_W-1:0]         eps,
  output logic                                   vld_out,
  output logic [weno5ud_pkg::S_W-1:0]           s_out
);
  import weno5ud_pkg::*;

  logic [SMOOTH_LAT-1:0]     vld_r;
  logic signed [SQ_W-1:0]    a_q, b_q;
  logic signed [2*SQ_W-1:0]  aa_nxt, bb_nxt;
  logic [2*SQ_W-1:0]         aa_r, bb_r;
  logic [X_W-1:0]            x;
  div12_t                    d3, d2, d1, d0;
  logic [Q_W-1:0]            qhi_r;
  logic [3:0]                rem_r;
  logic [31:0]               xlo_r;
  logic [EPS_W-1:0]          eps_eff;
  logic [S_W-1:0]            s_nxt, s_r;

  // floor to Q.16, then square
  assign a_q    = SQ_W'(a_diff >>> 8);
  assign b_q    = SQ_W'(b_diff >>> 8);
  assign aa_nxt = a_q * a_q;
  assign bb_nxt = b_q * b_q;

  // upper two digits of the divide by 12
  assign x  = X_W'(aa_r) * X_W'(13) + X_W'(bb_r) * X_W'(3);
  assign d3 = div12_part(4'd0, x[63:48]);
  assign d2 = div12_part(d3.r, x[47:32]);

  // lower two digits, then epsilon (zero acts as one)
  assign d1      = div12_part(rem_r, xlo_r[31:16]);
  assign d0      = div12_part(d1.r, xlo_r[15:0]);
  assign eps_eff = (eps == '0) ? EPS_W'(1) : eps;
  assign s_nxt   = S_W'({qhi_r, d1.q, d0.q}) + S_W'({eps_eff, 8'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SMOOTH_LAT-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aa_r  <= $unsigned(aa_nxt);
      bb_r  <= $unsigned(bb_nxt);
      qhi_r <= {d3.q, d2.q};
      rem_r <= d2.r;
      xlo_r <= x[31:0];
      s_r   <= s_nxt;
    end
  end

  assign vld_out = vld_r[SMOOTH_LAT-1];
  assign s_out   = s_r;

endmodule

### src/weno5ud_qdiv.sv
// Pipelined restoring divider: quo = floor(num * 2^31 / den) for num <= den.
`include "weno5_upwind_derivative_core_assert.svh"
module weno5ud_qdiv (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           vld_in,
  input  logic [weno5ud_pkg::DEN_W-1:0] num,
  input  logic [weno5ud_pkg::DEN_W-1:0] den,
  output logic                           vld_out,
  output logic [weno5ud_pkg::Q_W-1:0]   quo
);
  import weno5ud_pkg::*;

  localparam int REM_W = DEN_W + 1;

  logic [QDIV_LAT-1:0] vld_r;
  logic [REM_W-1:0]    rem_r   [QDIV_LAT-1];
  logic [DEN_W-1:0]    den_r   [QDIV_LAT-1];
  logic [Q_W-1:0]      quo_r   [QDIV_LAT];
  logic [REM_W-1:0]    rem_nxt [QDIV_LAT];
  logic [Q_W-1:0]      quo_nxt [QDIV_LAT];

  for (genvar g = 0; g < QDIV_LAT; g++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;

    if (g == 0) begin : g_first
      assign rem_in = REM_W'(num);
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign den_in = den_r[g-1];
      assign quo_in = quo_r[g-1];
    end

    // compare, subtract, double: one quotient bit per step
    always_comb begin
      logic [REM_W-1:0] rem_v;
      logic [Q_W-1:0]   quo_v;
      logic             take;
      rem_v = rem_in;
      quo_v = quo_in;
      for (int j = 0; j < QDIV_STEPS; j++) begin
        take = (rem_v >= REM_W'(den_in));
        if (take) begin
          rem_v = rem_v - REM_W'(den_in);
        end
        rem_v = {rem_v[REM_W-2:0], 1'b0};
        quo_v = {quo_v[Q_W-2:0], take};
      end
      rem_nxt[g] = rem_v;
      quo_nxt[g] = quo_v;
    end

    if (g < QDIV_LAT - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g] <= rem_nxt[g];
          den_r[g] <= den_in;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[g] <= quo_nxt[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QDIV_LAT-2:0], vld_in};
    end
  end

  assign vld_out = vld_r[QDIV_LAT-1];
  assign quo     = quo_r[QDIV_LAT-1];

  // callers keep num <= den, so the quotient never passes one
  `W5UD_ASSERT_IMPL(a_quo_le_one, vld_out, quo <= {1'b1, {(Q_W-1){1'b0}}}, "qdiv quotient above one")

endmodule

### src/weno5ud_rec.sv
// One WENO5-JS reconstruction on five samples, fully pipelined.
module weno5ud_rec (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   vld_in,
  input  logic                                   left,
  input  logic [weno5ud_pkg::EPS_W-1:0]         eps,
  input  logic signed [weno5ud_pkg::DATA_W-1:0] smp_a,
  input  logic signed [weno5ud_pkg::DATA_W-1:0] smp_b,
  input  logic signed [weno5ud_pkg::DATA_W-1:0] smp_c,
  input  logic signed [weno5ud_pkg::DATA_W-1:0] smp_d,
  input  logic signed [weno5ud_pkg::DATA_W-1:0] smp_e,
  output logic                                   vld_out,
  output logic signed [weno5ud_pkg::RES_W-1:0]  res
);
  import weno5ud_pkg::*;

  localparam int P_W   = W_W + F_W + 1;
  localparam int ACC_W = P_W + 2;

  typedef struct packed {
    logic [2:0][F_W-1:0] f;
    logic                left;
  } side_t;

  // stage 1: differences and candidate numerators
  logic signed [NUM_W-1:0]  a, b, c, d, e;
  logic signed [DIFF_W-1:0] ad_nxt [3], bd_nxt [3], ad_r [3], bd_r [3];
  logic signed [NUM_W-1:0]  num_nxt [3], num_r [3];
  logic                     left1_r, vld1_r;

  // smoothness and candidate division
  logic [2:0]               s_vld;
  logic                     vld_s;
  logic [S_W-1:0]           s_k [3];
  logic [MAG_W-1:0]         mag [3];
  div6_t                    d6a [3], d6b [3], d6c [3];
  logic [2:0]               neg2_r, neg3_r;
  logic [2:0][15:0]         q2_r, q3_hi_r, q3_mid_r;
  logic [2:0][2:0]          r2_r, r3_r;
  logic [2:0][31:0]         lo2_r;
  logic [2:0][15:0]         lo3_r;
  logic                     left2_r, left3_r;
  side_t                    side4_nxt, side4_r;

  // weights
  logic [S_W-1:0]           m_nxt, m5_r, m6_r;
  logic [S_W-1:0]           s5_r [3], s6_r [3];
  logic [SH_W-1:0]          sh_nxt [3], sh6_r [3];
  logic [Q_W-1:0]           mp_nxt [3], sp_nxt [3], mp7_r [3], sp7_r [3];
  logic                     vld5_r, vld6_r, vld7_r;
  side_t                    side5_r, side6_r, side7_r;
  side_t                    dl1_r [QDIV_LAT];
  logic [2:0]               r_vld;
  logic [Q_W-1:0]           ratio [3];
  logic [2*Q_W-1:0]         rsq [3];
  logic [Q_W-1:0]           q_r [3];
  logic                     vldq_r;
  side_t                    sideq_r;
  logic [DEN_W-1:0]         t_nxt [3], t_r [3];
  logic [DEN_W-1:0]         sum_nxt, sum_r;
  logic                     vldt_r;
  side_t                    sidet_r;
  side_t                    dl2_r [QDIV_LAT];
  logic [2:0]               w_vld;
  logic [Q_W-1:0]           wq [3];

  // weighted sum
  logic signed [P_W-1:0]    p_nxt [3], p_r [3];
  logic                     vldp_r, vlda_r;
  logic signed [ACC_W-1:0]  acc;
  logic signed [RES_W-1:0]  res_r;

  assign a = NUM_W'(smp_a);
  assign b = NUM_W'(smp_b);
  assign c = NUM_W'(smp_c);
  assign d = NUM_W'(smp_d);
  assign e = NUM_W'(smp_e);

  always_comb begin
    ad_nxt[0] = DIFF_W'((a + c) - 2 * b);
    bd_nxt[0] = DIFF_W'((a + 3 * c) - 4 * b);
    ad_nxt[1] = DIFF_W'((b + d) - 2 * c);
    bd_nxt[1] = DIFF_W'(b - d);
    ad_nxt[2] = DIFF_W'((c + e) - 2 * d);
    bd_nxt[2] = DIFF_W'((3 * c + e) - 4 * d);
    if (left) begin
      num_nxt[0] = 2 * a - 7 * b + 11 * c;
      num_nxt[1] = -b + 5 * c + 2 * d;
      num_nxt[2] = 2 * c + 5 * d - e;
    end else begin
      num_nxt[0] = -a + 5 * b + 2 * c;
      num_nxt[1] = 2 * b + 5 * c - d;
      num_nxt[2] = 11 * c - 7 * d + 2 * e;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_smooth
    weno5ud_smooth u_smooth (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (vld1_r),
      .a_diff  (ad_r[k]),
      .b_diff  (bd_r[k]),
      .eps     (eps),
      .vld_out (s_vld[k]),
      .s_out   (s_k[k])
    );
  end
  assign vld_s = &s_vld;

  // candidates: truncate toward zero, one base-2^16 digit per stage
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = MAG_W'(num_r[k] < 0 ? -num_r[k] : num_r[k]);
      d6a[k] = div6_part(3'd0, mag[k][47:32]);
      d6b[k] = div6_part(r2_r[k], lo2_r[k][31:16]);
      d6c[k] = div6_part(r3_r[k], lo3_r[k]);
      side4_nxt.f[k] = neg3_r[k] ? F_W'(-{q3_hi_r[k], q3_mid_r[k], d6c[k].q})
                                 : F_W'({q3_hi_r[k], q3_mid_r[k], d6c[k].q});
    end
    side4_nxt.left = left3_r;
  end

  // minimum, then the shift that brings each indicator into 32 bits
  always_comb begin
    m_nxt = s_k[0];
    if (s_k[1] < m_nxt) m_nxt = s_k[1];
    if (s_k[2] < m_nxt) m_nxt = s_k[2];
    for (int k = 0; k < 3; k++) begin
      sh_nxt[k] = '0;
      for (int i = 0; i < S_W - Q_W; i++) begin
        if (s5_r[k][Q_W + i]) sh_nxt[k] = SH_W'(i + 1);
      end
      mp_nxt[k] = Q_W'(m6_r >> sh6_r[k]);
      sp_nxt[k] = Q_W'(s6_r[k] >> sh6_r[k]);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_ratio
    weno5ud_qdiv u_ratio (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (vld7_r),
      .num     (DEN_W'(mp7_r[k])),
      .den     (DEN_W'(sp7_r[k])),
      .vld_out (r_vld[k]),
      .quo     (ratio[k])
    );
  end

  // linear weights follow the transaction whose squared ratios sit in q_r
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rsq[k]   = (2*Q_W)'(ratio[k]) * (2*Q_W)'(ratio[k]);
      t_nxt[k] = DEN_W'(sideq_r.left ? G_LEFT[k] : G_RIGHT[k]) * DEN_W'(q_r[k]);
    end
    sum_nxt = t_nxt[0] + t_nxt[1] + t_nxt[2];
  end

  for (genvar k = 0; k < 3; k++) begin : g_weight
    weno5ud_qdiv u_weight (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (vldt_r),
      .num     (t_r[k]),
      .den     (sum_r),
      .vld_out (w_vld[k]),
      .quo     (wq[k])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p_nxt[k] = $signed({1'b0, wq[k][Q_W-1:Q_W-W_W]}) * $signed(dl2_r[QDIV_LAT-1].f[k]);
    end
    acc = ACC_W'(p_r[0]) + ACC_W'(p_r[1]) + ACC_W'(p_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
      vldq_r <= 1'b0;
      vldt_r <= 1'b0;
      vldp_r <= 1'b0;
      vlda_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_in;
      vld5_r <= vld_s;
      vld6_r <= vld5_r;
      vld7_r <= vld6_r;
      vldq_r <= &r_vld;
      vldt_r <= vldq_r;
      vldp_r <= &w_vld;
      vlda_r <= vldp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      left1_r <= left;
      left2_r <= left1_r;
      left3_r <= left2_r;
      for (int k = 0; k < 3; k++) begin
        ad_r[k]     <= ad_nxt[k];
        bd_r[k]     <= bd_nxt[k];
        num_r[k]    <= num_nxt[k];
        neg2_r[k]   <= (num_r[k] < 0);
        q2_r[k]     <= d6a[k].q;
        r2_r[k]     <= d6a[k].r;
        lo2_r[k]    <= mag[k][31:0];
        neg3_r[k]   <= neg2_r[k];
        q3_hi_r[k]  <= q2_r[k];
        q3_mid_r[k] <= d6b[k].q;
        r3_r[k]     <= d6b[k].r;
        lo3_r[k]    <= lo2_r[k][15:0];
        s5_r[k]     <= s_k[k];
        s6_r[k]     <= s5_r[k];
        sh6_r[k]    <= sh_nxt[k];
        mp7_r[k]    <= mp_nxt[k];
        sp7_r[k]    <= sp_nxt[k];
        q_r[k]      <= rsq[k][2*Q_W-2:Q_W-1];
        t_r[k]      <= t_nxt[k];
        p_r[k]      <= p_nxt[k];
      end
      side4_r <= side4_nxt;
      m5_r    <= m_nxt;
      m6_r    <= m5_r;
      side5_r <= side4_r;
      side6_r <= side5_r;
      side7_r <= side6_r;
      dl1_r[0] <= side7_r;
      dl2_r[0] <= sidet_r;
      for (int i = 1; i < QDIV_LAT; i++) begin
        dl1_r[i] <= dl1_r[i-1];
        dl2_r[i] <= dl2_r[i-1];
      end
      sideq_r <= dl1_r[QDIV_LAT-1];
      sidet_r <= sideq_r;
      sum_r   <= sum_nxt;
      res_r   <= RES_W'(acc >>> FRAC_BITS);
    end
  end

  assign vld_out = vlda_r;
  assign res     = res_r;

endmodule

### src/weno5_upwind_derivative_core.sv
// Top level of the fifth-order WENO upwind flux-difference core.
// The core takes one stencil transaction (velocity and seven Q8.24 samples)
// per clock and returns one Q8.24 flux difference fp - fm per transaction,
// in order. A positive velocity selects the left-biased pair of
// reconstructions, zero or negative the right-biased pair. Both
// reconstructions run side by side in a 27-stage pipeline: one stage of
// differences, three of smoothness indicators, three for the minimum and
// the normalising shift, eight for the Q1.31 ratio divider, two for the
// squared ratios and linear weights, eight for the weight divider and two
// for the weighted sum. The saturating subtract sits in the output
// register, behind both reconstruction pipelines. Throughput is one
// transaction per cycle; a stall on the result side freezes the whole
// pipeline and holds in_chan.ready low until the output register is
// taken. smooth_epsilon resets to 17 (about 1e-6); a written zero acts
// as one. Write it only while the pipeline is empty.
`include "weno5_upwind_derivative_core_assert.svh"
module weno5_upwind_derivative_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [weno5ud_pkg::EPS_W-1:0] cfg_wr_data,
  weno5ud_in_if.sink                    in_chan,
  weno5ud_out_if.source                 out_chan
);
  import weno5ud_pkg::*;

  localparam logic signed [DATA_W-1:0] SAT_HI = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_LO = {1'b1, {(DATA_W-1){1'b0}}};

  logic                      en;
  logic                      pos;
  logic [EPS_W-1:0]          eps_r;
  logic                      rec_vld_p, rec_vld_m;
  logic signed [RES_W-1:0]   res_p, res_m;
  logic signed [RES_W:0]     diff;
  logic signed [DATA_W-1:0]  out_data_nxt, out_data_r;
  logic                      out_vld_r;

  // advance everything when the output register is empty or being taken
  assign en            = !out_vld_r || out_chan.ready;
  assign in_chan.ready = en;

  // positive velocity: left-biased stencils
  assign pos = (in_chan.velocity > 0);

  weno5ud_rec u_rec_p (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (in_chan.valid),
    .left    (pos),
    .eps     (eps_r),
    .smp_a   (pos ? in_chan.sample_m2 : in_chan.sample_m1),
    .smp_b   (pos ? in_chan.sample_m1 : in_chan.sample_c),
    .smp_c   (pos ? in_chan.sample_c  : in_chan.sample_p1),
    .smp_d   (pos ? in_chan.sample_p1 : in_chan.sample_p2),
    .smp_e   (pos ? in_chan.sample_p2 : in_chan.sample_p3),
    .vld_out (rec_vld_p),
    .res     (res_p)
  );

  weno5ud_rec u_rec_m (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (in_chan.valid),
    .left    (pos),
    .eps     (eps_r),
    .smp_a   (pos ? in_chan.sample_m3 : in_chan.sample_m2),
    .smp_b   (pos ? in_chan.sample_m2 : in_chan.sample_m1),
    .smp_c   (pos ? in_chan.sample_m1 : in_chan.sample_c),
    .smp_d   (pos ? in_chan.sample_c  : in_chan.sample_p1),
    .smp_e   (pos ? in_chan.sample_p1 : in_chan.sample_p2),
    .vld_out (rec_vld_m),
    .res     (res_m)
  );

  // exact difference, then clamp to the 32-bit range
  always_comb begin
    diff = (RES_W+1)'(res_p) - (RES_W+1)'(res_m);
    if (diff > (RES_W+1)'(SAT_HI)) begin
      out_data_nxt = SAT_HI;
    end else if (diff < (RES_W+1)'(SAT_LO)) begin
      out_data_nxt = SAT_LO;
    end else begin
      out_data_nxt = DATA_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r     <= EPS_RESET;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        eps_r <= cfg_wr_data;
      end
      if (en) begin
        out_vld_r <= rec_vld_p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_chan.valid           = out_vld_r;
  assign out_chan.flux_difference = out_data_r;

  `W5UD_ASSERT_IMPL(a_pair_aligned, 1'b1, rec_vld_p == rec_vld_m, "fp and fm pipelines out of step")
  `W5UD_ASSERT_NEXT(a_frozen_on_stall, !en, $stable(rec_vld_p), "pipeline moved during a stall")
  `W5UD_ASSERT_NEXT(a_sat_high, en && rec_vld_p && diff > (RES_W+1)'(SAT_HI), out_data_r == SAT_HI, "positive overflow not clamped")

endmodule
